// ----- sv/sacp_pkg.sv -----
// sacp_pkg: shared types and constants for the serial adc channel poller
// used by sacp_csr, sacp_seq and serial_adc_channel_poller_top; depends on nothing

package sacp_pkg;

   localparam int LIST_DEPTH_DEFAULT = 8;
   localparam int SAMPLE_BITS        = 8;
   localparam int PERIOD_W           = 12;
   localparam int TICK_W             = 13;
   localparam int ORDER_W            = 16;
   localparam int LENGTH_W           = 4;
   localparam int CSR_ADDR_W         = 4;
   localparam int CSR_DATA_W         = 32;
   localparam int ORDER_ENTRIES      = ORDER_W / 2;

   // register index codes, byte address is 4 * index
   typedef enum logic [1:0] {
      REG_ENABLE  = 2'd0,
      REG_PERIOD  = 2'd1,
      REG_ORDER   = 2'd2,
      REG_LENGTH  = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DRIVE  = 3'd1,
      PH_WAIT   = 3'd2,
      PH_SAMPLE = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef struct packed {
      logic                enable;
      logic [PERIOD_W-1:0] period_ticks;
      logic [ORDER_W-1:0]  channel_order;
      logic [LENGTH_W-1:0] list_length;
   } cfg_type;

   typedef struct packed {
      logic                   chip_select_n;
      logic                   drive_enable;
      logic                   data_level;
      logic                   sample_done;
      logic [1:0]             sample_channel;
      logic [SAMPLE_BITS-1:0] sample_value;
   } result_type;

endpackage

// ----- sv/sacp_csr.sv -----
// sacp_csr: apb-style configuration registers with readback
// depends on sacp_pkg

module sacp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sacp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sacp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sacp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output sacp_pkg::cfg_type                  cfg
);

   sacp_pkg::cfg_type       cfg_ff, cfg_in;
   sacp_pkg::reg_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign index      = sacp_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            sacp_pkg::REG_ENABLE: cfg_in.enable        = csr_pwdata[0];
            sacp_pkg::REG_PERIOD: cfg_in.period_ticks  = csr_pwdata[sacp_pkg::PERIOD_W-1:0];
            sacp_pkg::REG_ORDER:  cfg_in.channel_order = csr_pwdata[sacp_pkg::ORDER_W-1:0];
            sacp_pkg::REG_LENGTH: cfg_in.list_length   = csr_pwdata[sacp_pkg::LENGTH_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         sacp_pkg::REG_ENABLE: csr_prdata = sacp_pkg::CSR_DATA_W'(cfg_ff.enable);
         sacp_pkg::REG_PERIOD: csr_prdata = sacp_pkg::CSR_DATA_W'(cfg_ff.period_ticks);
         sacp_pkg::REG_ORDER:  csr_prdata = sacp_pkg::CSR_DATA_W'(cfg_ff.channel_order);
         sacp_pkg::REG_LENGTH: csr_prdata = sacp_pkg::CSR_DATA_W'(cfg_ff.list_length);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.period_ticks  <= sacp_pkg::PERIOD_W'(1);
         cfg_ff.channel_order <= '0;
         cfg_ff.list_length   <= sacp_pkg::LENGTH_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/sacp_seq.sv -----
// sacp_seq: conversion sequencer, advances one tick per accepted item
// depends on sacp_pkg; result is combinational from state and config

module sacp_seq #(
   parameter int LIST_DEPTH = sacp_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  data_in,
   input  sacp_pkg::cfg_type     cfg,
   output sacp_pkg::result_type  result
);

   localparam int PosW     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LenW     = 5;
   localparam int Span     = (LIST_DEPTH > sacp_pkg::ORDER_ENTRIES) ?
                             LIST_DEPTH : sacp_pkg::ORDER_ENTRIES;
   localparam int BitW     = 3;
   localparam logic [LenW-1:0] DepthLen = LenW'(LIST_DEPTH);
   localparam logic [BitW-1:0] LastBit  = BitW'(sacp_pkg::SAMPLE_BITS - 1);
   localparam logic [BitW-1:0] LastMux  = BitW'(3);

   sacp_pkg::phase_type              phase_ff, phase_in, eff_phase;
   logic [sacp_pkg::TICK_W-1:0]      tick_ff, tick_in, eff_tick, tick_inc;
   logic [BitW-1:0]                  bit_ff, bit_in, eff_bit;
   logic [sacp_pkg::SAMPLE_BITS-1:0] shift_ff, shift_in, eff_shift;
   logic [PosW-1:0]                  pos_ff, pos_in;

   logic [sacp_pkg::TICK_W-1:0]      period, wait_len, drive_len;
   logic [LenW-1:0]                  len_eff;
   logic [2*Span-1:0]                order_ext;
   logic [1:0]                       channel;
   logic                             starting;

   // zero period acts as one
   assign period    = (cfg.period_ticks == '0) ? sacp_pkg::TICK_W'(1) :
                      sacp_pkg::TICK_W'(cfg.period_ticks);
   assign wait_len  = period + (period >> 1);
   assign drive_len = (eff_bit >= LastMux) ? sacp_pkg::TICK_W'(1) : period;

   always_comb begin
      if (cfg.list_length == '0) begin
         len_eff = LenW'(1);
      end else if (LenW'(cfg.list_length) > DepthLen) begin
         len_eff = DepthLen;
      end else begin
         len_eff = LenW'(cfg.list_length);
      end
   end

   // entries past the register read as channel zero
   assign order_ext = (2*Span)'(cfg.channel_order);
   assign channel   = order_ext[{pos_ff, 1'b0} +: 2];

   // an idle sequencer starts a conversion on the tick it is enabled
   assign starting  = (phase_ff == sacp_pkg::PH_IDLE);
   assign eff_phase = starting ? sacp_pkg::PH_DRIVE : phase_ff;
   assign eff_tick  = starting ? '0 : tick_ff;
   assign eff_bit   = starting ? '0 : bit_ff;
   assign eff_shift = starting ? '0 : shift_ff;
   assign tick_inc  = eff_tick + sacp_pkg::TICK_W'(1);

   // next state
   always_comb begin
      phase_in = eff_phase;
      tick_in  = tick_inc;
      bit_in   = eff_bit;
      shift_in = eff_shift;
      pos_in   = pos_ff;
      if (!cfg.enable) begin
         phase_in = sacp_pkg::PH_IDLE;
         tick_in  = '0;
         bit_in   = '0;
         shift_in = shift_ff;
      end else begin
         unique case (eff_phase)
            sacp_pkg::PH_DRIVE: begin
               if (tick_inc >= drive_len) begin
                  tick_in = '0;
                  if (eff_bit >= LastMux) begin
                     bit_in   = '0;
                     phase_in = sacp_pkg::PH_WAIT;
                  end else begin
                     bit_in = eff_bit + BitW'(1);
                  end
               end
            end
            sacp_pkg::PH_WAIT: begin
               if (tick_inc >= wait_len) begin
                  tick_in  = '0;
                  bit_in   = '0;
                  phase_in = sacp_pkg::PH_SAMPLE;
               end
            end
            sacp_pkg::PH_SAMPLE: begin
               if (eff_tick == '0) begin
                  shift_in = {eff_shift[sacp_pkg::SAMPLE_BITS-2:0], data_in};
               end
               if (tick_inc >= period) begin
                  tick_in = '0;
                  if (eff_bit >= LastBit) begin
                     bit_in   = '0;
                     phase_in = sacp_pkg::PH_DONE;
                  end else begin
                     bit_in = eff_bit + BitW'(1);
                  end
               end
            end
            sacp_pkg::PH_DONE: begin
               phase_in = sacp_pkg::PH_DRIVE;
               tick_in  = '0;
               bit_in   = '0;
               shift_in = '0;
               if (LenW'(pos_ff) + LenW'(1) >= len_eff) begin
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + PosW'(1);
               end
            end
            default: begin
               phase_in = sacp_pkg::PH_IDLE;
               tick_in  = '0;
               bit_in   = '0;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      result = '0;
      result.chip_select_n = 1'b1;
      if (cfg.enable) begin
         unique case (eff_phase)
            sacp_pkg::PH_DRIVE: begin
               result.chip_select_n = 1'b0;
               result.drive_enable  = 1'b1;
               if (eff_bit < BitW'(2)) begin
                  result.data_level = 1'b1;
               end else if (eff_bit == BitW'(2)) begin
                  result.data_level = channel[0];
               end else begin
                  result.data_level = channel[1];
               end
            end
            sacp_pkg::PH_WAIT,
            sacp_pkg::PH_SAMPLE: begin
               result.chip_select_n = 1'b0;
            end
            sacp_pkg::PH_DONE: begin
               result.sample_done    = 1'b1;
               result.sample_channel = channel;
               result.sample_value   = eff_shift;
            end
            default: begin
               result.chip_select_n = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sacp_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ----- sv/serial_adc_channel_poller_top.sv -----
// serial_adc_channel_poller_top: top level, registers, sequencer and result register
// depends on sacp_pkg, sacp_csr and sacp_seq
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_data_in
//   rsp      out        rsp_valid / rsp_ready     rsp_chip_select_n .. rsp_sample_value
//   csr      in         apb psel/penable/pready   csr_paddr, csr_pwdata, csr_prdata
//
// one item per cycle while the rsp side drains: each accepted tick steps the sequencer
// once and its result lands in the result register on the same edge, so the result
// appears in the cycle after acceptance. req_ready stays high while the result register
// is empty or being drained, so a stalled rsp side holds exactly one item. synchronous
// reset clears the sequencer and result valid, sets register defaults, holds req_ready low.

module serial_adc_channel_poller_top #(
   parameter int LIST_DEPTH = sacp_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_data_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_chip_select_n,
   output logic                                rsp_drive_enable,
   output logic                                rsp_data_level,
   output logic                                rsp_sample_done,
   output logic [1:0]                          rsp_sample_channel,
   output logic [sacp_pkg::SAMPLE_BITS-1:0]    rsp_sample_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sacp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sacp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sacp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   sacp_pkg::cfg_type    cfg;
   sacp_pkg::result_type result, result_ff;
   logic                 accept;
   logic                 rsp_valid_ff, rsp_valid_in;

   sacp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sacp_seq #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .data_in (req_data_in),
      .cfg     (cfg),
      .result  (result)
   );

   assign req_ready    = ~reset & (~rsp_valid_ff | rsp_ready);
   assign accept       = req_valid & req_ready;
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chip_select_n  = result_ff.chip_select_n;
   assign rsp_drive_enable   = result_ff.drive_enable;
   assign rsp_data_level     = result_ff.data_level;
   assign rsp_sample_done    = result_ff.sample_done;
   assign rsp_sample_channel = result_ff.sample_channel;
   assign rsp_sample_value   = result_ff.sample_value;

endmodule
